FILE: rtl/scpr_pkg.sv
// Shared constants and helpers for the second-chance page replacement core.
// No dependencies; imported by the top level.
package scpr_pkg;

	localparam int unsigned MAX_FRAMES_DEF = 16;
	localparam int unsigned PAGE_W         = 32;
	localparam int unsigned CNT_W          = 32;
	localparam int unsigned CFG_W          = 5;
	localparam int unsigned IDX_OUT_W      = 4;
	localparam int unsigned FRAMES_RESET   = 16;

	// clamp the configured frame count to 1..max_frames
	function automatic int unsigned eff_frames(input logic [CFG_W-1:0] v,
			input int unsigned max_frames);
		int unsigned r;
		r = int'(v);
		if (r == 0) begin
			r = 1;
		end else if (r > max_frames) begin
			r = max_frames;
		end
		return r;
	endfunction

endpackage

FILE: rtl/second_chance_page_replacement_core.sv
// Second-chance (clock) page replacement core.
// Depends on scpr_pkg for widths, reset values and the frame count clamp.
//
// Usage:
//   s_tdata[31:0] carries a page number; page zero is taken and dropped.
//   Each nonzero page gives one result item on the m_ side: m_tuser is the
//   hit flag, m_tdata holds the frame, request count and fault count.
//   cfg_we/cfg_wdata write the frame count (1..MAX_FRAMES after clamping);
//   a write empties all frames, zeroes the counts and parks the hand on the
//   last frame. Write it only while the core is idle.
// Timing:
//   One comparator walks the resident frames one per cycle from a page
//   table memory with a registered read; a fault with all frames full then
//   steps the clock hand one frame per cycle over the reference bits.
//   The result is loaded once the walk matches on a hit, once it has passed
//   every valid frame on a fill fault, or once the hand finds a frame with
//   a clear reference bit on a replacing fault. s_tready is low while an
//   item is worked on and rises the cycle after its result is loaded.
// Reset and stall:
//   arst_n empties all frames and sets the frame count to 16 (clamped).
//   A finished result sits in the output register until m_tready; the next
//   item is accepted meanwhile, and its result waits until the register frees.
module second_chance_page_replacement_core
	import scpr_pkg::*;
#(
	parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,   // [31:0] page_number
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [71:0]       m_tdata,   // [3:0] frame_index, [35:4] request_count,
	                                     // [67:36] miss_count, [71:68] zero
	output logic              m_tuser    // [0] hit
);

	localparam int unsigned FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
	localparam int unsigned N_RST =
		(FRAMES_RESET > MAX_FRAMES) ? MAX_FRAMES : FRAMES_RESET;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOOK = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [CFG_W-1:0]       cfg_q;
	logic [PAGE_W-1:0]      page_q;
	logic [CW-1:0]          fill_q;
	logic [FW-1:0]          hand_q;
	logic [MAX_FRAMES-1:0]  ref_q;
	logic [CNT_W-1:0]       req_cnt_q;
	logic [CNT_W-1:0]       miss_cnt_q;
	logic [CW-1:0]          rd_idx_q;
	logic                   cmp_vld_q;
	logic [FW-1:0]          cmp_idx_q;
	logic [PAGE_W-1:0]      rd_data_q;
	logic [FW-1:0]          scan_q;
	logic                   hit_q;
	logic [FW-1:0]          frame_q;
	logic                   out_vld_q;
	logic                   out_hit_q;
	logic [IDX_OUT_W-1:0]   out_frame_q;
	logic [CNT_W-1:0]       out_req_q;
	logic [CNT_W-1:0]       out_miss_q;

	logic [PAGE_W-1:0]      mem [MAX_FRAMES];

	logic [CW-1:0]          n_frames;
	logic                   match;
	logic                   rd_more;
	logic                   out_free;
	logic                   out_load;
	logic [FW-1:0]          hand_next;
	logic [FW-1:0]          scan_next;
	logic                   mem_we;

	assign n_frames  = CW'(eff_frames(cfg_q, MAX_FRAMES));
	assign match     = cmp_vld_q && (rd_data_q == page_q);
	assign rd_more   = rd_idx_q < fill_q;
	assign out_free  = !out_vld_q || m_tready;
	assign out_load  = (state_q == ST_DONE) && out_free;
	assign hand_next = ((CW'(hand_q) + CW'(1)) >= n_frames) ? '0 : hand_q + FW'(1);
	assign scan_next = ((CW'(scan_q) + CW'(1)) >= n_frames) ? '0 : scan_q + FW'(1);
	assign mem_we    = out_load && !hit_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_hit_q;
	assign m_tdata  = {4'b0000, out_miss_q, out_req_q, out_frame_q};

	// page table memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[frame_q] <= page_q;
		end
		rd_data_q <= mem[rd_idx_q[FW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= CFG_W'(FRAMES_RESET);
			fill_q      <= '0;
			hand_q      <= FW'(N_RST - 1);
			ref_q       <= '0;
			req_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			rd_idx_q    <= '0;
			cmp_vld_q   <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (m_tready && !out_load) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_we) begin
						cfg_q      <= cfg_wdata;
						fill_q     <= '0;
						hand_q     <= FW'(eff_frames(cfg_wdata, MAX_FRAMES) - 1);
						ref_q      <= '0;
						req_cnt_q  <= '0;
						miss_cnt_q <= '0;
					end else if (s_tvalid && (s_tdata != '0)) begin
						page_q    <= s_tdata;
						req_cnt_q <= (req_cnt_q == '1) ? req_cnt_q : req_cnt_q + CNT_W'(1);
						rd_idx_q  <= '0;
						cmp_vld_q <= 1'b0;
						state_q   <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					cmp_idx_q <= rd_idx_q[FW-1:0];
					cmp_vld_q <= rd_more && !match;
					if (rd_more) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					priority if (match) begin
						hit_q   <= 1'b1;
						frame_q <= cmp_idx_q;
						state_q <= ST_DONE;
					end else if (!cmp_vld_q && !rd_more) begin
						hit_q      <= 1'b0;
						miss_cnt_q <= (miss_cnt_q == '1) ? miss_cnt_q
							: miss_cnt_q + CNT_W'(1);
						if (fill_q < n_frames) begin
							frame_q <= fill_q[FW-1:0];
							fill_q  <= fill_q + CW'(1);
							state_q <= ST_DONE;
						end else begin
							scan_q  <= hand_next;
							state_q <= ST_SCAN;
						end
					end else begin
					end
				end
				ST_SCAN: begin
					if (ref_q[scan_q]) begin
						ref_q[scan_q] <= 1'b0;
						scan_q        <= scan_next;
					end else begin
						hand_q  <= scan_q;
						frame_q <= scan_q;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						ref_q[frame_q] <= hit_q;
						out_vld_q      <= 1'b1;
						out_hit_q      <= hit_q;
						out_frame_q    <= IDX_OUT_W'(frame_q);
						out_req_q      <= req_cnt_q;
						out_miss_q     <= miss_cnt_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
